### sv/assert_macros.svh
// Assertion macros shared by the RTL of the arming interlock.
// Simulation gets the checks; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### sv/iai_pkg.sv
// ----------------------------------------------------------------------------
// iai_pkg
// Types and constants of the ignition arming interlock.
// ----------------------------------------------------------------------------
package iai_pkg;

  localparam int LEVEL_W = 10;
  localparam int NEED_W  = 8;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [LEVEL_W-1:0] ARM_THRESHOLD_RST   = 10'd400;
  localparam logic [NEED_W-1:0]  DEBOUNCE_NEEDED_RST = 8'd10;
  localparam logic [NEED_W-1:0]  CNT_MAX             = 8'd255;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARM_THRESHOLD   = 1'b0,
    CFG_DEBOUNCE_NEEDED = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] arm_threshold;
    logic [NEED_W-1:0]  debounce_needed;
  } cfg_t;

  // One polled sample
  typedef struct packed {
    logic [LEVEL_W-1:0] master_level;
    logic               stage_button;
    logic               fire_button;
    logic               valve_a_button;
    logic               valve_b_button;
  } sample_t;

  // One result beat
  typedef struct packed {
    logic armed;
    logic arm_changed;
    logic stage_flag;
    logic ignition_on;
    logic fire_pulse;
    logic valve_a_flag;
    logic valve_b_flag;
    logic valve_a_open;
    logic valve_b_open;
    logic beep;
  } result_t;

endpackage

### sv/iai_core.sv
// ----------------------------------------------------------------------------
// iai_core
// Debounce, button edge and fire logic; holds the interlock state and
// advances it by one sample on each step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iai_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  iai_pkg::cfg_t    cfg,
  input  iai_pkg::sample_t smp,
  output iai_pkg::result_t res
);

  // State registers
  logic                      stable_arm;
  logic [iai_pkg::NEED_W-1:0] mismatch_count;
  logic [2:0]                previous_buttons;  // bit0 stage, bit1 A, bit2 B
  logic [3:0]                output_flags;      // stage, ignition, A, B
  logic [1:0]                valve_positions;   // bit0 A, bit1 B

  logic                      stable_arm_next;
  logic [iai_pkg::NEED_W-1:0] mismatch_count_next;
  logic [2:0]                previous_buttons_next;
  logic [3:0]                output_flags_next;
  logic [1:0]                valve_positions_next;

  logic                      raw_arm;
  logic [iai_pkg::NEED_W-1:0] cnt_inc;
  logic                      changed;
  logic                      stage_edge;
  logic                      va_edge;
  logic                      vb_edge;
  logic                      stage_tgl;
  logic                      fired;
  logic                      va_tgl;
  logic                      vb_tgl;
  logic                      va_base;
  logic                      vb_base;

  // Debounce: saturating mismatch counter against the stable state
  always_comb begin
    raw_arm = (smp.master_level > cfg.arm_threshold);
    cnt_inc = (mismatch_count == iai_pkg::CNT_MAX) ? mismatch_count
                                                   : mismatch_count + 8'd1;
    stable_arm_next     = stable_arm;
    mismatch_count_next = '0;
    changed             = 1'b0;
    if (raw_arm != stable_arm) begin
      if (cnt_inc >= cfg.debounce_needed) begin
        stable_arm_next = raw_arm;
        changed         = 1'b1;
      end else begin
        mismatch_count_next = cnt_inc;
      end
    end
  end

  // Buttons, fire and valves, evaluated on the new stable state
  always_comb begin
    stage_edge = smp.stage_button & ~previous_buttons[0];
    va_edge    = smp.valve_a_button & ~previous_buttons[1];
    vb_edge    = smp.valve_b_button & ~previous_buttons[2];
    stage_tgl  = output_flags[0] ^ stage_edge;
    fired      = ~smp.fire_button & stage_tgl;
    va_tgl     = output_flags[2] ^ va_edge;
    vb_tgl     = output_flags[3] ^ vb_edge;
    // fire closes both valves; a later valve edge in the same sample wins
    va_base    = fired ? 1'b0 : valve_positions[0];
    vb_base    = fired ? 1'b0 : valve_positions[1];

    previous_buttons_next = {smp.valve_b_button, smp.valve_a_button,
                             smp.stage_button};
    if (stable_arm_next) begin
      output_flags_next    = {vb_tgl, va_tgl, output_flags[1] ^ fired, stage_tgl};
      valve_positions_next = {vb_edge ? vb_tgl : vb_base,
                              va_edge ? va_tgl : va_base};
    end else begin
      output_flags_next    = '0;
      valve_positions_next = '0;
    end

    res.armed        = stable_arm_next;
    res.arm_changed  = changed;
    res.stage_flag   = output_flags_next[0];
    res.ignition_on  = output_flags_next[1];
    res.fire_pulse   = stable_arm_next & fired;
    res.valve_a_flag = output_flags_next[2];
    res.valve_b_flag = output_flags_next[3];
    res.valve_a_open = valve_positions_next[0];
    res.valve_b_open = valve_positions_next[1];
    res.beep         = stable_arm_next & (va_edge | vb_edge);
  end

  // State update, one sample per step
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_arm       <= 1'b0;
      mismatch_count   <= '0;
      previous_buttons <= '0;
      output_flags     <= '0;
      valve_positions  <= '0;
    end else if (step) begin
      stable_arm       <= stable_arm_next;
      mismatch_count   <= mismatch_count_next;
      previous_buttons <= previous_buttons_next;
      output_flags     <= output_flags_next;
      valve_positions  <= valve_positions_next;
    end
  end

  // Checks
  `ASSERT_IMPLY(a_disarm_clear, clk, rst, !stable_arm, !(|output_flags) && !(|valve_positions))
  `ASSERT_IMPLY(a_valve_a_flag, clk, rst, valve_positions[0], output_flags[2])
  `ASSERT_IMPLY(a_valve_b_flag, clk, rst, valve_positions[1], output_flags[3])
  `ASSERT_IMPLY(a_fire_staged, clk, rst, step && res.fire_pulse, res.stage_flag && res.armed)
  `ASSERT_NEXT(a_change_clears, clk, rst, step && res.arm_changed, mismatch_count == '0)

endmodule

### sv/ignition_arming_interlock.sv
// Path: an accepted sample is held in the input register, and its result
// beat is then held in the result register.
// Throughput: one sample per cycle while the output side takes beats.
// Reset (rst, synchronous): disarmed, all flags and valves closed, counter
// and button history cleared; threshold 400, debounce count 10.
// ----------------------------------------------------------------------------
// ignition_arming_interlock
// Master arming debounce and button interlock for stage, ignition and
// valves, with valid/ready channels and a register write port.
// ----------------------------------------------------------------------------
module ignition_arming_interlock (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [iai_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iai_pkg::CFG_W-1:0]     cfg_data,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [iai_pkg::LEVEL_W-1:0]   master_level,
  input  logic                          stage_button,
  input  logic                          fire_button,
  input  logic                          valve_a_button,
  input  logic                          valve_b_button,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          armed,
  output logic                          arm_changed,
  output logic                          stage_flag,
  output logic                          ignition_on,
  output logic                          fire_pulse,
  output logic                          valve_a_flag,
  output logic                          valve_b_flag,
  output logic                          valve_a_open,
  output logic                          valve_b_open,
  output logic                          beep
);

  iai_pkg::cfg_t    cfg;
  iai_pkg::sample_t s1_smp;
  logic             s1_valid;
  iai_pkg::result_t res;
  iai_pkg::result_t out_res;
  logic             out_free;
  logic             step;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_threshold   <= iai_pkg::ARM_THRESHOLD_RST;
      cfg.debounce_needed <= iai_pkg::DEBOUNCE_NEEDED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iai_pkg::CFG_ARM_THRESHOLD:
          cfg.arm_threshold <= cfg_data[iai_pkg::LEVEL_W-1:0];
        iai_pkg::CFG_DEBOUNCE_NEEDED:
          cfg.debounce_needed <= cfg_data[iai_pkg::NEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the sample stage moves on when the result register is free
  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid && out_free;
  assign in_ready = !s1_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_smp.master_level   <= master_level;
      s1_smp.stage_button   <= stage_button;
      s1_smp.fire_button    <= fire_button;
      s1_smp.valve_a_button <= valve_a_button;
      s1_smp.valve_b_button <= valve_b_button;
    end
  end

  // Interlock logic and state
  iai_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cfg  (cfg),
    .smp  (s1_smp),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign armed        = out_res.armed;
  assign arm_changed  = out_res.arm_changed;
  assign stage_flag   = out_res.stage_flag;
  assign ignition_on  = out_res.ignition_on;
  assign fire_pulse   = out_res.fire_pulse;
  assign valve_a_flag = out_res.valve_a_flag;
  assign valve_b_flag = out_res.valve_b_flag;
  assign valve_a_open = out_res.valve_a_open;
  assign valve_b_open = out_res.valve_b_open;
  assign beep         = out_res.beep;

endmodule
